### hdl/mu8_pkg.sv
// ----------------------------------------------------------------------------
// mu8_pkg
// Shared types, constants and helpers for the modified UTF-8 converter.
// ----------------------------------------------------------------------------
package mu8_pkg;

    localparam int WIN_DEPTH = 6;
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int IDX_W     = $clog2(WIN_DEPTH);
    localparam int SUB_W     = 3;
    localparam int ESC_LEN   = 6;
    localparam int SUPP_LEN  = 4;

    localparam logic [7:0] BYTE_ZERO_LEAD  = 8'hC0;
    localparam logic [7:0] BYTE_ZERO_TRAIL = 8'h80;
    localparam logic [7:0] BYTE_SURR_LEAD  = 8'hED;

    typedef logic [WIN_DEPTH-1:0][7:0] window_t;

    // Surrogate pair pattern, entry 0 is the oldest byte
    localparam window_t PAT_MASK = {8'hC0, 8'hF0, 8'hFF, 8'hC0, 8'hF0, 8'hFF};
    localparam window_t PAT_VAL  = {8'h80, 8'hB0, 8'hED, 8'h80, 8'hA0, 8'hED};

    // Escape text for an embedded zero: backslash u 0 0 0 0
    localparam logic [ESC_LEN-1:0][7:0] ESC_BYTES =
        {8'h30, 8'h30, 8'h30, 8'h30, 8'h75, 8'h5C};

    typedef enum logic [2:0]
    {
        ACT_NONE,
        ACT_RAW,
        ACT_ZERO,
        ACT_SUPP,
        ACT_WAIT
    } act_kind_t;

    typedef struct packed
    {
        act_kind_t        kind;
        logic             emit;
        logic [7:0]       data;
        logic             done;
        logic [CNT_W-1:0] pop;
    } head_act_t;

    function automatic logic [SUPP_LEN-1:0][7:0] supp_bytes(input window_t w);
        logic [9:0]                 hh;
        logic [9:0]                 ll;
        logic [20:0]                cp;
        logic [SUPP_LEN-1:0][7:0]   res;
        hh     = {w[1][3:0], w[2][5:0]};
        ll     = {w[4][3:0], w[5][5:0]};
        cp     = 21'h10000 + {1'b0, hh, ll};
        res[0] = {5'b11110, cp[20:18]};
        res[1] = {2'b10, cp[17:12]};
        res[2] = {2'b10, cp[11:6]};
        res[3] = {2'b10, cp[5:0]};
        return res;
    endfunction

endpackage

### hdl/mu8_stream_if.sv
// ----------------------------------------------------------------------------
// mu8 stream interfaces
// Valid/ready byte channels for the converter input and output.
// ----------------------------------------------------------------------------
interface mu8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface mu8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### hdl/mu8_head_decode.sv
// ----------------------------------------------------------------------------
// mu8_head_decode
// Classifies the bytes at the head of the window and picks the next
// output byte, whether it ends its sequence and how many window bytes it consumes.
// ----------------------------------------------------------------------------
module mu8_head_decode
(
    input  mu8_pkg::window_t                win,
    input  logic [mu8_pkg::CNT_W-1:0]       cnt,
    input  logic [mu8_pkg::SUB_W-1:0]       sub,
    input  logic                            last_in_win,
    output mu8_pkg::head_act_t              act
);
    import mu8_pkg::*;

    logic                       mism;
    act_kind_t                  kind;
    logic [SUPP_LEN-1:0][7:0]   supp;

    always_comb
    begin
        mism = 1'b0;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if ((CNT_W'(i) < cnt) && ((win[i] & PAT_MASK[i]) != PAT_VAL[i]))
            begin
                mism = 1'b1;
            end
        end
    end

    assign supp = supp_bytes(win);

    always_comb
    begin
        if (cnt == '0)
        begin
            kind = ACT_NONE;
        end
        else if (win[0] == BYTE_ZERO_LEAD)
        begin
            if (cnt < CNT_W'(2))
            begin
                kind = ACT_WAIT;
            end
            else if (win[1] == BYTE_ZERO_TRAIL)
            begin
                kind = ACT_ZERO;
            end
            else
            begin
                kind = ACT_RAW;
            end
        end
        else if (win[0] == BYTE_SURR_LEAD)
        begin
            if (mism)
            begin
                kind = ACT_RAW;
            end
            else if (cnt == CNT_W'(WIN_DEPTH))
            begin
                kind = ACT_SUPP;
            end
            else
            begin
                kind = ACT_WAIT;
            end
        end
        else
        begin
            kind = ACT_RAW;
        end

        // end of string: an unresolved prefix goes out as is
        if (kind == ACT_WAIT && last_in_win)
        begin
            kind = ACT_RAW;
        end
    end

    always_comb
    begin
        act      = '0;
        act.kind = kind;
        unique case (kind)
            ACT_RAW:
            begin
                act.emit = 1'b1;
                act.data = win[0];
                act.done = 1'b1;
                act.pop  = CNT_W'(1);
            end
            ACT_ZERO:
            begin
                act.emit = 1'b1;
                act.data = ESC_BYTES[sub];
                act.done = (sub == SUB_W'(ESC_LEN - 1));
                act.pop  = CNT_W'(2);
            end
            ACT_SUPP:
            begin
                act.emit = 1'b1;
                act.data = supp[sub[1:0]];
                act.done = (sub == SUB_W'(SUPP_LEN - 1));
                act.pop  = CNT_W'(WIN_DEPTH);
            end
            ACT_NONE, ACT_WAIT:
            begin
                act.emit = 1'b0;
            end
            default:
            begin
                act.emit = 1'b0;
            end
        endcase
    end

endmodule

### hdl/modified_utf8_to_utf8_converter.sv
// ----------------------------------------------------------------------------
// modified_utf8_to_utf8_converter
// A byte that resolves at once passes through the window register and then the
// output register; one output byte per cycle while the output is not stalled.
// The single output port sets the rate: a zero pair expands to six bytes, a
// surrogate pair to four, during which the six-byte window fills and stalls input.
// After a last byte, input waits until the window has drained.
// Reset clears the window count, step counter, last flag and output valid.
// ----------------------------------------------------------------------------
module modified_utf8_to_utf8_converter
(
    input  logic        clk,
    input  logic        rst_n,
    mu8_in_if.sink      in_stream,
    mu8_out_if.source   out_stream
);
    import mu8_pkg::*;

    window_t            window_reg;
    window_t            window_next;
    window_t            window_shift;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   cnt_after;
    logic [SUB_W-1:0]   sub_reg;
    logic [SUB_W-1:0]   sub_next;
    logic               last_reg;
    logic               last_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_byte_next;
    logic               out_last_reg;
    logic               out_last_next;

    head_act_t          act;
    logic               out_free;
    logic               advance;
    logic               accept;
    logic               out_last_now;
    logic [CNT_W-1:0]   pop_now;

    mu8_head_decode u_decode
    (
        .win         (window_reg),
        .cnt         (cnt_reg),
        .sub         (sub_reg),
        .last_in_win (last_reg),
        .act         (act)
    );

    assign out_free       = !out_valid_reg || out_stream.ready;
    assign advance        = act.emit && out_free;
    assign in_stream.ready = !last_reg && (cnt_reg < CNT_W'(WIN_DEPTH));
    assign accept         = in_stream.valid && in_stream.ready;
    assign out_last_now   = last_reg && act.done && (act.pop == cnt_reg);
    assign pop_now        = (advance && act.done) ? act.pop : '0;

    always_comb
    begin
        unique case (pop_now)
            CNT_W'(1): window_shift = window_reg >> 8;
            CNT_W'(2): window_shift = window_reg >> 16;
            default:   window_shift = window_reg;
        endcase

        cnt_after   = cnt_reg - pop_now;
        window_next = window_shift;
        if (accept)
        begin
            window_next[cnt_after[IDX_W-1:0]] = in_stream.in_byte;
        end
        cnt_next = cnt_after + CNT_W'(accept);

        last_next = last_reg;
        if (advance && out_last_now)
        begin
            last_next = 1'b0;
        end
        else if (accept && in_stream.in_last)
        begin
            last_next = 1'b1;
        end

        sub_next = sub_reg;
        if (advance)
        begin
            sub_next = act.done ? '0 : sub_reg + SUB_W'(1);
        end

        out_valid_next = out_free ? act.emit : out_valid_reg;
        out_byte_next  = advance ? act.data : out_byte_reg;
        out_last_next  = advance ? out_last_now : out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sub_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            sub_reg       <= sub_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg   <= window_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_stream.valid    = out_valid_reg;
    assign out_stream.out_byte = out_byte_reg;
    assign out_stream.out_last = out_last_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(WIN_DEPTH))
        else $error("window count above depth");

    a_sub_in_multi: assert property (@(posedge clk) disable iff (!rst_n)
        (sub_reg != '0) |-> (act.kind == ACT_ZERO || act.kind == ACT_SUPP))
        else $error("step counter running outside a multi-byte sequence");

    a_no_wait_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (act.kind == ACT_WAIT) |-> !last_reg)
        else $error("window waiting for input after last byte");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && out_last_now) |=> (cnt_reg == '0 && !last_reg))
        else $error("window not empty after final byte");

endmodule
